[sv/piaw_pkg.sv]
// ----------------------------------------------------------------------------
// piaw_pkg
// types and constants shared by the pi controller with anti-windup
// ----------------------------------------------------------------------------
package piaw_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned IE_W     = SAMPLE_W + 1;
    localparam int unsigned IPROD_W  = IE_W + GAIN_W;
    localparam int unsigned PPROD_W  = SAMPLE_W + GAIN_W;
    localparam int unsigned SUM_W    = IPROD_W + 1;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 4;

    localparam logic signed [GAIN_W-1:0]   PROP_GAIN_RST  = '0;
    localparam logic signed [GAIN_W-1:0]   INTEG_GAIN_RST = '0;
    localparam logic signed [SAMPLE_W-1:0] UPPER_RST      = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] LOWER_RST      = 16'sh8000;

    typedef enum logic [1:0] {
        REG_PROP_GAIN   = 2'd0,
        REG_INTEG_GAIN  = 2'd1,
        REG_UPPER_LIMIT = 2'd2,
        REG_LOWER_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   prop_gain;
        logic signed [GAIN_W-1:0]   integ_gain;
        logic signed [SAMPLE_W-1:0] upper_limit;
        logic signed [SAMPLE_W-1:0] lower_limit;
    } t_cfg;

endpackage

[sv/piaw_in_if.sv]
// ----------------------------------------------------------------------------
// piaw_in_if
// input word channel: error sample and hold flag
// ----------------------------------------------------------------------------
interface piaw_in_if import piaw_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] err_sample;
    logic                       hold_integral;

    modport source (output valid, output err_sample, output hold_integral, input ready);
    modport sink   (input valid, input err_sample, input hold_integral, output ready);
endinterface

[sv/piaw_out_if.sv]
// ----------------------------------------------------------------------------
// piaw_out_if
// output word channel: limited drive and limit flag
// ----------------------------------------------------------------------------
interface piaw_out_if import piaw_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] drive_out;
    logic                       at_limit;

    modport source (output valid, output drive_out, output at_limit, input ready);
    modport sink   (input valid, input drive_out, input at_limit, output ready);
endinterface

[sv/piaw_regs.sv]
// ----------------------------------------------------------------------------
// piaw_regs
// apb configuration registers: gains and limits
// ----------------------------------------------------------------------------
module piaw_regs import piaw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= PROP_GAIN_RST;
            r_cfg.integ_gain  <= INTEG_GAIN_RST;
            r_cfg.upper_limit <= UPPER_RST;
            r_cfg.lower_limit <= LOWER_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PROP_GAIN:   r_cfg.prop_gain   <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= pwdata[GAIN_W-1:0];
                REG_UPPER_LIMIT: r_cfg.upper_limit <= pwdata[SAMPLE_W-1:0];
                REG_LOWER_LIMIT: r_cfg.lower_limit <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PROP_GAIN:   prdata = r_cfg.prop_gain;
            REG_INTEG_GAIN:  prdata = r_cfg.integ_gain;
            REG_UPPER_LIMIT: prdata = APB_DW'(r_cfg.upper_limit);
            REG_LOWER_LIMIT: prdata = APB_DW'(r_cfg.lower_limit);
            default:         prdata = '0;
        endcase
    end

endmodule

[sv/piaw_integ.sv]
// ----------------------------------------------------------------------------
// piaw_integ
// integrator: accumulate, round up, anti-windup clamp of the accumulator
// ----------------------------------------------------------------------------
module piaw_integ import piaw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_upd,
    input  logic signed [IPROD_W-1:0] i_iprod,
    input  t_cfg                      i_cfg,
    output logic signed [ACC_W-1:0]   o_accum
);

    logic signed [ACC_W-1:0] r_accum;
    logic signed [ACC_W-1:0] n_accum;
    logic signed [SUM_W-1:0] w_sum;
    logic        [ACC_W-1:0] w_word;

    assign w_sum  = {i_iprod[IPROD_W-1], i_iprod}
                  + {{(SUM_W-ACC_W){r_accum[ACC_W-1]}}, r_accum};
    // ceiling on the dropped residue, wraps in 32 bits
    assign w_word = w_sum[ACC_W+FRAC_W-1:FRAC_W] + ACC_W'(|w_sum[FRAC_W-1:0]);

    always_comb begin
        priority if ($signed(w_word) > ACC_W'(i_cfg.upper_limit)) begin
            n_accum = {i_cfg.upper_limit, {FRAC_W{1'b0}}};
        end else if ($signed(w_word) < ACC_W'(i_cfg.lower_limit)) begin
            n_accum = {i_cfg.lower_limit, {FRAC_W{1'b0}}};
        end else begin
            n_accum = w_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (i_upd) begin
            r_accum <= n_accum;
        end
    end

    // accumulator after the current word
    assign o_accum = n_accum;

endmodule

[sv/piaw_limit.sv]
// ----------------------------------------------------------------------------
// piaw_limit
// output stage: proportional plus integral, clamp, result register
// ----------------------------------------------------------------------------
module piaw_limit import piaw_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic signed [PPROD_W-1:0] i_pprod,
    input  logic signed [ACC_W-1:0]   i_accum,
    input  t_cfg                      i_cfg,
    output logic signed [SAMPLE_W-1:0] o_drive,
    output logic                      o_at_limit
);

    logic signed [SUM_W-1:0]    w_osum;
    logic signed [ACC_W-1:0]    w_o;
    logic signed [ACC_W-1:0]    w_up;
    logic signed [ACC_W-1:0]    w_lo;
    logic signed [ACC_W-1:0]    w_o1;
    logic                       w_hi_hit;
    logic                       w_lo_hit;
    logic signed [SAMPLE_W-1:0] n_drive;
    logic signed [SAMPLE_W-1:0] r_drive;
    logic                       r_at_limit;

    assign w_osum = {i_pprod[PPROD_W-1], i_pprod, 1'b0}
                  + {{(SUM_W-ACC_W){i_accum[ACC_W-1]}}, i_accum};
    assign w_o    = w_osum[ACC_W+FRAC_W-1:FRAC_W];
    assign w_up   = ACC_W'(i_cfg.upper_limit);
    assign w_lo   = ACC_W'(i_cfg.lower_limit);

    // upper clamp first, lower clamp wins when limits are inverted
    assign w_hi_hit = (w_o >= w_up);
    assign w_o1     = w_hi_hit ? w_up : w_o;
    assign w_lo_hit = (w_o1 <= w_lo);
    assign n_drive  = w_lo_hit ? i_cfg.lower_limit : w_o1[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive    <= n_drive;
            r_at_limit <= w_hi_hit || w_lo_hit;
        end
    end

    assign o_drive    = r_drive;
    assign o_at_limit = r_at_limit;

endmodule

[sv/pi_controller_anti_windup_unit.sv]
// ----------------------------------------------------------------------------
// pi_controller_anti_windup_unit
// parallel pi controller, q15 data, 32-bit integrator with anti-windup
// ----------------------------------------------------------------------------
// usage:
//   i_in takes one word per control tick: err_sample and hold_integral.
//   o_out gives one word per input word: drive_out and at_limit.
//   gains and limits are written over the apb port while no word is in flight.
// datapath: an accepted input word loads the input register, which feeds
//   both multiplies, the integrator add, round-up and clamp and the output
//   clamp, which load the result register.
// throughput: one word per cycle while o_out is not held; the accumulator
//   loop closes in that same cycle.
// reset: gains clear to zero, limits go to full q15 range, previous error
//   and accumulator clear, both registers empty.
// stall: when o_out is held the result register keeps its word, one more
//   word waits in the input register, then i_in.ready drops.
// ----------------------------------------------------------------------------
module pi_controller_anti_windup_unit import piaw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    piaw_in_if.sink           i_in,
    piaw_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;

    logic                        r_v1;
    logic                        r_v2;
    logic signed [SAMPLE_W-1:0]  r_prev;
    logic signed [SAMPLE_W-1:0]  r1_err;
    logic                        r1_hold;
    logic signed [IE_W-1:0]      w_ie;
    logic signed [IPROD_W-1:0]   w_iprod;
    logic signed [PPROD_W-1:0]   w_pprod;
    logic signed [ACC_W-1:0]     w_accum;
    logic                        w_acc_in;
    logic                        w_adv1;

    piaw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv1     = r_v1 && (!r_v2 || o_out.ready);
    assign i_in.ready = !r_v1 || w_adv1;
    assign w_acc_in   = i_in.valid && i_in.ready;

    assign w_ie = {r_prev[SAMPLE_W-1], r_prev}
                + (r1_hold ? IE_W'(0) : {r1_err[SAMPLE_W-1], r1_err});

    assign w_iprod = IPROD_W'(w_ie) * IPROD_W'(w_cfg.integ_gain);
    assign w_pprod = PPROD_W'(r1_err) * PPROD_W'(w_cfg.prop_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_prev <= '0;
        end else begin
            r_v1 <= w_acc_in || (r_v1 && !w_adv1);
            r_v2 <= w_adv1 || (r_v2 && !o_out.ready);
            if (w_adv1) begin
                r_prev <= r1_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r1_err  <= i_in.err_sample;
            r1_hold <= i_in.hold_integral;
        end
    end

    piaw_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_adv1),
        .i_iprod (w_iprod),
        .i_cfg   (w_cfg),
        .o_accum (w_accum)
    );

    piaw_limit u_limit (
        .i_clk      (i_clk),
        .i_load     (w_adv1),
        .i_pprod    (w_pprod),
        .i_accum    (w_accum),
        .i_cfg      (w_cfg),
        .o_drive    (o_out.drive_out),
        .o_at_limit (o_out.at_limit)
    );

    assign o_out.valid = r_v2;

endmodule

[dv/piaw_drive_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piaw_drive_check
// watches the error and drive channels and the apb port of the pi controller,
// keeps its own copy of gains, limits, previous error and integrator, works
// out the drive word each error word should give, and compares every drive
// word in order; register reads are checked against the tracked settings
// ----------------------------------------------------------------------------
module piaw_drive_check import piaw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    piaw_in_if                i_err_mon,
    piaw_out_if               i_drive_mon,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic [APB_DW-1:0] i_prdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] drive;
        logic                       at_limit;
    } t_drive_word;

    t_cfg                       cfg;
    logic signed [SAMPLE_W-1:0] last_err;
    logic [ACC_W-1:0]           integ_acc;
    t_drive_word                drive_q[$];
    int                         fail_total;
    int                         checked_total;

    assign o_fail_count = fail_total;
    assign o_checked    = checked_total;

    initial begin
        fail_total    = 0;
        checked_total = 0;
        o_pending     = 0;
    end

    function automatic t_drive_word pi_step(input logic signed [SAMPLE_W-1:0] err,
                                            input logic hold);
        logic signed [63:0] ie, ig, pg, acc, sum, rv, up, lo, e64, outsum, o;
        logic [31:0]        rounded;
        t_drive_word        res;
        ig  = 64'(cfg.integ_gain);
        pg  = 64'(cfg.prop_gain);
        up  = 64'(cfg.upper_limit);
        lo  = 64'(cfg.lower_limit);
        acc = 64'($signed(integ_acc));
        ie  = 64'(last_err);
        e64 = 64'(err);
        if (!hold) begin
            ie = ie + e64;
        end
        sum = ie * ig + acc;
        // ceiling of sum / 2^16, wrapping in 32 bits
        rounded = sum[47:16];
        if (sum[15:0] != 16'h0) begin
            rounded = rounded + 32'd1;
        end
        rv = 64'($signed(rounded));
        if (rv > up) begin
            integ_acc = {cfg.upper_limit, 16'h0};
        end else if (rv < lo) begin
            integ_acc = {cfg.lower_limit, 16'h0};
        end else begin
            integ_acc = sum[31:0];
        end
        last_err = err;
        acc = 64'($signed(integ_acc));
        outsum = e64 * pg * 64'sd2 + acc;
        o = 64'($signed(outsum[47:16]));
        res.at_limit = 1'b0;
        // lower clamp last so it wins when the limits are inverted
        if (o >= up) begin
            o = up;
            res.at_limit = 1'b1;
        end
        if (o <= lo) begin
            o = lo;
            res.at_limit = 1'b1;
        end
        res.drive = o[15:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_drive_word want;
        t_reg_idx    idx;
        logic [31:0] reg_val;
        logic [31:0] reg_mask;
        if (!i_rst_n) begin
            cfg.prop_gain   = PROP_GAIN_RST;
            cfg.integ_gain  = INTEG_GAIN_RST;
            cfg.upper_limit = UPPER_RST;
            cfg.lower_limit = LOWER_RST;
            last_err        = '0;
            integ_acc       = '0;
            drive_q.delete();
        end else begin
            idx = t_reg_idx'(i_paddr[3:2]);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (idx)
                    REG_PROP_GAIN:   cfg.prop_gain   = i_pwdata;
                    REG_INTEG_GAIN:  cfg.integ_gain  = i_pwdata;
                    REG_UPPER_LIMIT: cfg.upper_limit = i_pwdata[15:0];
                    REG_LOWER_LIMIT: cfg.lower_limit = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                reg_mask = 32'h0000ffff;
                case (idx)
                    REG_PROP_GAIN: begin
                        reg_val  = cfg.prop_gain;
                        reg_mask = 32'hffffffff;
                    end
                    REG_INTEG_GAIN: begin
                        reg_val  = cfg.integ_gain;
                        reg_mask = 32'hffffffff;
                    end
                    REG_UPPER_LIMIT: reg_val = {16'h0, cfg.upper_limit};
                    default:         reg_val = {16'h0, cfg.lower_limit};
                endcase
                if ((i_prdata & reg_mask) !== (reg_val & reg_mask)) begin
                    $display("%0t: register %s read expected %h got %h",
                             $time, idx.name(), reg_val & reg_mask, i_prdata & reg_mask);
                    fail_total++;
                end
            end
            if (i_err_mon.valid && i_err_mon.ready) begin
                drive_q.push_back(pi_step(i_err_mon.err_sample, i_err_mon.hold_integral));
            end
            if (i_drive_mon.valid && i_drive_mon.ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: drive word with none expected, got %0d limit %b",
                             $time, i_drive_mon.drive_out, i_drive_mon.at_limit);
                    fail_total++;
                end else begin
                    want = drive_q.pop_front();
                    checked_total++;
                    if (i_drive_mon.drive_out !== want.drive) begin
                        $display("%0t: drive_out expected %0d got %0d",
                                 $time, want.drive, i_drive_mon.drive_out);
                        fail_total++;
                    end
                    if (i_drive_mon.at_limit !== want.at_limit) begin
                        $display("%0t: at_limit expected %b got %b",
                                 $time, want.at_limit, i_drive_mon.at_limit);
                        fail_total++;
                    end
                end
            end
        end
        o_pending <= drive_q.size();
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus for the pi controller with anti-windup: directed corner words
// (full-scale errors, extreme gains, round-up and output wrap, inverted and
// equal limits) then random settings with random and walking error streams,
// random idles and stalls on both channels; the checker judges every word
// ----------------------------------------------------------------------------
module testbench;
    import piaw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int settings;
    int sent;
    bit steady;
    logic signed [SAMPLE_W-1:0] walk_err;

    piaw_in_if  err_ch ();
    piaw_out_if drive_ch ();

    pi_controller_anti_windup_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (err_ch),
        .o_out   (drive_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    piaw_drive_check drive_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_err_mon    (err_ch),
        .i_drive_mon  (drive_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // drive side back-pressure
    initial begin
        drive_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!steady && $urandom_range(0, 99) < 3) begin
                drive_ch.ready <= 1'b0;
                repeat ($urandom_range(4, 12)) @(posedge i_clk);
                drive_ch.ready <= 1'b1;
            end else begin
                drive_ch.ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    task automatic reg_access(input t_reg_idx idx, input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] pg, input logic [31:0] ig,
                                 input logic [15:0] up, input logic [15:0] lo);
        reg_access(REG_PROP_GAIN, 1'b1, pg);
        reg_access(REG_INTEG_GAIN, 1'b1, ig);
        reg_access(REG_UPPER_LIMIT, 1'b1, {16'h0, up});
        reg_access(REG_LOWER_LIMIT, 1'b1, {16'h0, lo});
        reg_access(REG_PROP_GAIN, 1'b0, '0);
        reg_access(REG_INTEG_GAIN, 1'b0, '0);
        reg_access(REG_UPPER_LIMIT, 1'b0, '0);
        reg_access(REG_LOWER_LIMIT, 1'b0, '0);
        settings++;
    endtask

    task automatic send_err(input logic [15:0] err, input logic hold);
        if (!steady && $urandom_range(0, 99) < 33) begin
            err_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        err_ch.valid         <= 1'b1;
        err_ch.err_sample    <= err;
        err_ch.hold_integral <= hold;
        @(posedge i_clk);
        while (!err_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic settle();
        err_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_gain(input int unsigned span);
        case ($urandom_range(0, 7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3, 4, 5: return $urandom_range(0, 2 * span - 1) - span;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_err(input bit walking);
        logic signed [16:0] next;
        if (walking) begin
            next = walk_err + $signed(17'($urandom_range(0, 2047)) - 17'sd1024);
            if ($urandom_range(0, 49) == 0) next = $urandom_range(0, 1) ? 17'sd32767 : -17'sd32768;
            if (next > 17'sd32767) next = 17'sd32767;
            if (next < -17'sd32768) next = -17'sd32768;
            walk_err = next[15:0];
            return walk_err;
        end
        case ($urandom_range(0, 5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_setting();
        logic signed [15:0] a, b, up, lo;
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 5))
            0: begin
                up = 16'sh7fff;
                lo = 16'sh8000;
            end
            1: begin
                up = a;
                lo = a;
            end
            2: begin
                up = (a < b) ? a : b;
                lo = (a < b) ? b : a;
            end
            default: begin
                up = (a < b) ? b : a;
                lo = (a < b) ? a : b;
            end
        endcase
        apply_setting(pick_gain(32'h20000), pick_gain(32'h1000), up, lo);
    endtask

    initial begin
        bit walking;
        settings = 0;
        sent     = 0;
        steady   = 1'b0;
        walk_err = '0;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        err_ch.valid         <= 1'b0;
        err_ch.err_sample    <= '0;
        err_ch.hold_integral <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-scale errors with moderate gains
        apply_setting(32'h00010000, 32'h00002000, 16'h7fff, 16'h8000);
        send_err(16'h0000, 1'b0);
        send_err(16'h7fff, 1'b0);
        send_err(16'h7fff, 1'b1);
        send_err(16'h8000, 1'b0);
        send_err(16'h8000, 1'b1);
        send_err(16'hffff, 1'b0);
        send_err(16'h0001, 1'b0);
        settle();

        // most negative gains: round-up wrap in the integrator, output wrap
        apply_setting(32'h80000000, 32'h80000000, 16'h7fff, 16'h8000);
        send_err(16'h8000, 1'b0);
        send_err(16'h8000, 1'b0);
        send_err(16'h7fff, 1'b0);
        send_err(16'h0000, 1'b1);
        settle();

        apply_setting(32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h8000);
        send_err(16'h7fff, 1'b0);
        send_err(16'h7fff, 1'b0);
        send_err(16'h8000, 1'b0);
        send_err(16'hffff, 1'b1);
        settle();

        // inverted limits
        apply_setting(32'h00008000, 32'h00001000, 16'hff9c, 16'h0064);
        send_err(16'd5000, 1'b0);
        send_err(-16'sd5000, 1'b0);
        send_err(16'h0000, 1'b0);
        send_err(16'd20, 1'b1);
        settle();

        // equal limits
        apply_setting(32'h00008000, 32'h00001000, 16'h0000, 16'h0000);
        send_err(16'd100, 1'b0);
        send_err(-16'sd100, 1'b0);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            random_setting();
            walking = (ph % 2 == 1);
            steady  = (ph == 3);
            for (int n = 0; n < 115; n++) begin
                if (ph == 6 && n == 50) settle();
                send_err(pick_err(walking), $urandom_range(0, 3) == 0);
            end
            settle();
            steady = 1'b0;
        end

        repeat (8) @(posedge i_clk);
        $display("summary: %0d error words over %0d gain and limit settings", sent, settings);
        $display("summary: %0d drive words compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
